FILE: rtl/core/pileup_base_string_parser_macros.svh
// Assertion helpers used by the checker file.
`ifndef PILEUP_BASE_STRING_PARSER_MACROS_SVH
`define PILEUP_BASE_STRING_PARSER_MACROS_SVH

// Clocked check, muted while reset is held.
`define PBSP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PBSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/pbsp_pkg.sv
`timescale 1ns / 1ps

package pbsp_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_SKIP_QUAL  = 2'd1,
        MODE_DIGITS     = 2'd2,
        MODE_SKIP_INDEL = 2'd3
    } parse_mode_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam int IN_W  = 24;
    localparam int OUT_W = 184;

    // Per-position parser state.
    typedef struct packed {
        logic [3:0][15:0] base;
        logic [3:0][15:0] rev;
        logic [15:0]      starts_cnt;
        logic [15:0]      ends_cnt;
        logic [15:0]      holes_cnt;
        logic [15:0]      claimed;
        logic             first;
        parse_mode_t      mode;
        logic [15:0]      indel;
        logic             bad;
        logic [17:0]      total;
    } pos_state_t;

    localparam pos_state_t POS_CLEAR = '{
        base:       '0,
        rev:        '0,
        starts_cnt: '0,
        ends_cnt:   '0,
        holes_cnt:  '0,
        claimed:    '0,
        first:      1'b1,
        mode:       MODE_NORMAL,
        indel:      '0,
        bad:        1'b0,
        total:      '0
    };

endpackage

FILE: rtl/core/pileup_base_string_parser.sv
`timescale 1ns / 1ps

// Pileup read-base string parser. One byte of a position's read-base column
// is taken per clock (s_tdata[7:0]), with s_tlast on the final byte; the
// claimed read count in s_tdata[23:8] is sampled on a position's first byte.
// Every byte updates the counters and parse mode in the cycle it is accepted,
// so the block sustains one byte per cycle. The result of a position is held
// in the output register from the cycle after its last byte until taken;
// s_tready drops only while that register is full and m_tready is low.
// Counters saturate at the smaller of MAX_DEPTH and 65535. parse_status is
// 0 ok, 1 unknown byte seen, 2 base total differs from reads_left.
module pileup_base_string_parser #(
    parameter int MAX_DEPTH = 65535
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [7:0] symbol, [23:8] claimed_reads
    input  logic [pbsp_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] count_a, [31:16] count_t, [47:32] count_g, [63:48] count_c,
    // [79:64] rev_a, [95:80] rev_t, [111:96] rev_g, [127:112] rev_c,
    // [143:128] read_starts, [159:144] read_ends, [175:160] reads_left,
    // [177:176] parse_status, [183:178] zero
    output logic [pbsp_pkg::OUT_W-1:0]  m_tdata
);
    import pbsp_pkg::*;

    pos_state_t state_reg;
    pos_state_t state_next;
    pos_state_t parse_nxt;
    logic       accept;
    logic       close_pos;

    assign s_tready  = !m_tvalid || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign close_pos = accept && s_tlast;

    pbsp_parse #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_parse (
        .symbol        (s_tdata[7:0]),
        .claimed_reads (s_tdata[23:8]),
        .cur           (state_reg),
        .nxt           (parse_nxt)
    );

    pbsp_result u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (close_pos),
        .fin      (parse_nxt),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    always_comb begin
        if (close_pos) begin
            state_next = POS_CLEAR;
        end else if (accept) begin
            state_next = parse_nxt;
        end else begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= POS_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/pbsp_parse.sv
`timescale 1ns / 1ps

module pbsp_parse #(
    parameter int MAX_DEPTH = 65535
) (
    input  logic [7:0]           symbol,
    input  logic [15:0]          claimed_reads,
    input  pbsp_pkg::pos_state_t cur,
    output pbsp_pkg::pos_state_t nxt
);
    import pbsp_pkg::*;

    localparam logic [15:0] CAP_LIMIT = (MAX_DEPTH < 65535) ? 16'(MAX_DEPTH) : 16'hFFFF;

    localparam logic [7:0] SYM_NUL    = 8'h00;
    localparam logic [7:0] SYM_UA     = 8'h41;
    localparam logic [7:0] SYM_UT     = 8'h54;
    localparam logic [7:0] SYM_UG     = 8'h47;
    localparam logic [7:0] SYM_UC     = 8'h43;
    localparam logic [7:0] SYM_LA     = 8'h61;
    localparam logic [7:0] SYM_LT     = 8'h74;
    localparam logic [7:0] SYM_LG     = 8'h67;
    localparam logic [7:0] SYM_LC     = 8'h63;
    localparam logic [7:0] SYM_CARET  = 8'h5E;
    localparam logic [7:0] SYM_DOLLAR = 8'h24;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_STAR   = 8'h2A;
    localparam logic [7:0] SYM_0      = 8'h30;
    localparam logic [7:0] SYM_9      = 8'h39;

    logic        base_hit;
    logic [1:0]  base_idx;
    logic        lower;
    logic        is_start;
    logic        is_end;
    logic        is_indel;
    logic        is_hole;
    logic        is_unknown;
    logic        is_digit;
    logic        do_normal;
    logic [19:0] indel_mul;
    logic [15:0] indel_dec;
    parse_mode_t mode_next;
    logic [15:0] indel_next;

    always_comb begin
        base_hit   = 1'b0;
        base_idx   = 2'd0;
        lower      = 1'b0;
        is_start   = 1'b0;
        is_end     = 1'b0;
        is_indel   = 1'b0;
        is_hole    = 1'b0;
        is_unknown = 1'b0;
        case (symbol)
            SYM_UA: begin base_hit = 1'b1; base_idx = 2'd0; end
            SYM_UT: begin base_hit = 1'b1; base_idx = 2'd1; end
            SYM_UG: begin base_hit = 1'b1; base_idx = 2'd2; end
            SYM_UC: begin base_hit = 1'b1; base_idx = 2'd3; end
            SYM_LA: begin base_hit = 1'b1; base_idx = 2'd0; lower = 1'b1; end
            SYM_LT: begin base_hit = 1'b1; base_idx = 2'd1; lower = 1'b1; end
            SYM_LG: begin base_hit = 1'b1; base_idx = 2'd2; lower = 1'b1; end
            SYM_LC: begin base_hit = 1'b1; base_idx = 2'd3; lower = 1'b1; end
            SYM_CARET:            is_start = 1'b1;
            SYM_DOLLAR:           is_end   = 1'b1;
            SYM_PLUS, SYM_MINUS:  is_indel = 1'b1;
            SYM_STAR:             is_hole  = 1'b1;
            default:              is_unknown = 1'b1;
        endcase
    end

    assign is_digit  = symbol inside {[SYM_0:SYM_9]};
    assign indel_mul = {1'b0, cur.indel, 3'b000} + {3'b000, cur.indel, 1'b0}
                     + {16'd0, symbol[3:0]};
    assign indel_dec = cur.indel - 16'd1;

    // A non-digit right after '+'/'-' with no length is parsed as a normal byte.
    assign do_normal = (symbol != SYM_NUL) &&
                       ((cur.mode == MODE_NORMAL) ||
                        (cur.mode == MODE_DIGITS && !is_digit && cur.indel == 16'd0));

    // Mode and indel length
    always_comb begin
        mode_next  = cur.mode;
        indel_next = cur.indel;
        if (do_normal) begin
            if (is_start) begin
                mode_next = MODE_SKIP_QUAL;
            end else if (is_indel) begin
                mode_next  = MODE_DIGITS;
                indel_next = 16'd0;
            end else begin
                mode_next = MODE_NORMAL;
            end
        end else if (symbol != SYM_NUL) begin
            case (cur.mode)
                MODE_SKIP_QUAL: begin
                    mode_next = MODE_NORMAL;
                end
                MODE_DIGITS: begin
                    if (is_digit) begin
                        indel_next = (indel_mul > 20'hFFFF) ? 16'hFFFF : indel_mul[15:0];
                    end else begin
                        indel_next = indel_dec;
                        mode_next  = (indel_dec == 16'd0) ? MODE_NORMAL : MODE_SKIP_INDEL;
                    end
                end
                MODE_SKIP_INDEL: begin
                    if (cur.indel != 16'd0) begin
                        indel_next = indel_dec;
                    end
                    if (cur.indel <= 16'd1) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                default: begin
                    mode_next = cur.mode;
                end
            endcase
        end
    end

    // Counters
    always_comb begin
        nxt         = cur;
        nxt.first   = 1'b0;
        nxt.claimed = cur.first ? claimed_reads : cur.claimed;
        nxt.mode    = mode_next;
        nxt.indel   = indel_next;
        if (do_normal) begin
            if (base_hit && cur.base[base_idx] < CAP_LIMIT) begin
                nxt.base[base_idx] = cur.base[base_idx] + 16'd1;
                nxt.total          = cur.total + 18'd1;
            end
            if (base_hit && lower && cur.rev[base_idx] < CAP_LIMIT) begin
                nxt.rev[base_idx] = cur.rev[base_idx] + 16'd1;
            end
            if (is_start && cur.starts_cnt < CAP_LIMIT) begin
                nxt.starts_cnt = cur.starts_cnt + 16'd1;
            end
            if (is_end && cur.ends_cnt < CAP_LIMIT) begin
                nxt.ends_cnt = cur.ends_cnt + 16'd1;
            end
            if (is_hole && cur.holes_cnt < CAP_LIMIT) begin
                nxt.holes_cnt = cur.holes_cnt + 16'd1;
            end
            if (is_unknown) begin
                nxt.bad = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/pbsp_result.sv
`timescale 1ns / 1ps

module pbsp_result (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  pbsp_pkg::pos_state_t fin,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [pbsp_pkg::OUT_W-1:0] m_tdata
);
    import pbsp_pkg::*;

    logic [15:0]      reads_left;
    logic [1:0]       status;
    logic [OUT_W-1:0] data_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;

    assign reads_left = (fin.claimed > fin.holes_cnt) ? (fin.claimed - fin.holes_cnt) : 16'd0;

    always_comb begin
        if (fin.bad) begin
            status = STATUS_BAD_CHAR;
        end else if (fin.total != {2'b00, reads_left}) begin
            status = STATUS_MISMATCH;
        end else begin
            status = STATUS_OK;
        end
    end

    assign data_next = {6'd0, status, reads_left, fin.ends_cnt, fin.starts_cnt,
                        fin.rev[3], fin.rev[2], fin.rev[1], fin.rev[0],
                        fin.base[3], fin.base[2], fin.base[1], fin.base[0]};

    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/pbsp_checker.sv
`timescale 1ns / 1ps

`include "pileup_base_string_parser_macros.svh"

module pbsp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pbsp_pkg::OUT_W-1:0]  m_tdata
);
    import pbsp_pkg::*;

    // Output register empty means a new request can always be taken.
    `PBSP_ASSERT_ALWAYS(a_ready_when_empty, aclk, !m_tvalid |-> s_tready, "ready low with empty output")

    // A result only follows an accepted last byte.
    `PBSP_ASSERT(a_result_from_last, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast), "result without last byte")

    `PBSP_ASSERT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `PBSP_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> (m_tdata[177:176] == STATUS_OK || m_tdata[177:176] == STATUS_BAD_CHAR || m_tdata[177:176] == STATUS_MISMATCH), "undefined status")

    // Reverse-strand counts are a subset of the base counts.
    `PBSP_ASSERT(a_rev_le_base, aclk, aresetn, m_tvalid |-> (m_tdata[79:64] <= m_tdata[15:0] && m_tdata[95:80] <= m_tdata[31:16] && m_tdata[111:96] <= m_tdata[47:32] && m_tdata[127:112] <= m_tdata[63:48]), "reverse count above base count")

endmodule

bind pileup_base_string_parser pbsp_checker u_checker (.*);
